>>> hdl/sgm_pkg.sv
// sgm_pkg: shared types and constants of the sobel gradient magnitude block
// used by sgm_front, sgm_fifo, sgm_back and the top level
package sgm_pkg;

  localparam int PIX_W   = 8;
  localparam int GRAD_W  = 11;   // signed gradient, -1020..1020
  localparam int SQR_W   = 20;   // one squared gradient, up to 1040400
  localparam int SUM_W   = 21;   // sum of both squares
  localparam int ROOT_W  = 22;   // root accumulator plus trial bit
  localparam int MAG_W   = 11;
  localparam int WIDTH_W = 12;
  localparam int HEIGHT_W = 16;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  localparam int MIN_WIDTH  = 3;
  localparam int MIN_HEIGHT = 3;
  localparam int BORDER     = 2;

  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 12'd640;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 16'd480;

  // largest power of four not above the max sum
  localparam logic [SUM_W-1:0] ROOT_START_BIT = 21'h100000;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 4'd1;

  typedef struct packed {
    logic                  valid;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_req_t;

  typedef struct packed {
    logic signed [GRAD_W-1:0] gx;
    logic signed [GRAD_W-1:0] gy;
    logic                     last;
  } grad_t;

  typedef struct packed {
    logic              empty;
    logic [QCNT_W-1:0] count;
  } q_status_t;

endpackage

>>> hdl/sgm_front.sv
// sgm_front: pixel intake, position counters, line stores, window and gradients
// depends on sgm_pkg; pushes gradient pairs into sgm_fifo
module sgm_front
  import sgm_pkg::*;
#(
  parameter int MAX_WIDTH = 2048
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_req_t         cfg_i,
  input  logic             push_i,
  input  logic [PIX_W-1:0] pixel_i,
  output logic             full_o,
  input  q_status_t        q_stat_i,
  output logic             q_push_o,
  output grad_t            q_data_o
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int WVAL_W = $clog2(MAX_WIDTH + 1);
  localparam int CMP_W = (WVAL_W > WIDTH_W) ? WVAL_W : WIDTH_W;
  localparam logic [CMP_W-1:0] MAX_W_EXT = CMP_W'(MAX_WIDTH);

  logic [WIDTH_W-1:0]  width_q;
  logic [HEIGHT_W-1:0] height_q;
  logic [COL_W-1:0]    col_q;
  logic [HEIGHT_W-1:0] row_q;

  logic [CMP_W-1:0]    width_ext, width_use;
  logic [COL_W-1:0]    col_last;
  logic [HEIGHT_W-1:0] row_last;
  logic                accept, cfg_hit;

  logic [PIX_W-1:0] upper_mem  [MAX_WIDTH];
  logic [PIX_W-1:0] middle_mem [MAX_WIDTH];
  logic [PIX_W-1:0] top_rd_q, mid_rd_q;

  logic             s1_valid_q, s1_res_q, s1_last_q;
  logic [PIX_W-1:0] s1_pix_q;
  logic [COL_W-1:0] s1_col_q;
  logic [PIX_W-1:0] win_q [6];

  logic [PIX_W+1:0] sum_a, sum_c, sum_t, sum_b;
  logic [QCNT_W:0]  credit;

  // clamp the geometry
  always_comb begin
    width_ext = CMP_W'(width_q);
    if (width_ext < CMP_W'(MIN_WIDTH)) begin
      width_use = CMP_W'(MIN_WIDTH);
    end else if (width_ext > MAX_W_EXT) begin
      width_use = MAX_W_EXT;
    end else begin
      width_use = width_ext;
    end
    col_last = COL_W'(width_use - CMP_W'(1));
    if (height_q < HEIGHT_W'(MIN_HEIGHT)) begin
      row_last = HEIGHT_W'(MIN_HEIGHT - 1);
    end else begin
      row_last = height_q - HEIGHT_W'(1);
    end
  end

  // room for every result already in flight
  assign credit = {1'b0, q_stat_i.count} + (QCNT_W + 1)'(s1_res_q);
  assign full_o = (credit >= (QCNT_W + 1)'(QDEPTH));
  assign accept = push_i && !full_o;
  assign cfg_hit = cfg_i.valid &&
                   (cfg_i.index == REG_IMAGE_WIDTH || cfg_i.index == REG_IMAGE_HEIGHT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= WIDTH_RESET;
      height_q   <= HEIGHT_RESET;
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
      s1_res_q   <= 1'b0;
    end else begin
      if (cfg_i.valid && cfg_i.index == REG_IMAGE_WIDTH) begin
        width_q <= cfg_i.data[WIDTH_W-1:0];
      end
      if (cfg_i.valid && cfg_i.index == REG_IMAGE_HEIGHT) begin
        height_q <= cfg_i.data[HEIGHT_W-1:0];
      end
      if (cfg_hit) begin
        col_q <= '0;
        row_q <= '0;
      end else if (accept) begin
        if (col_q == col_last) begin
          col_q <= '0;
          row_q <= (row_q == row_last) ? '0 : row_q + HEIGHT_W'(1);
        end else begin
          col_q <= col_q + COL_W'(1);
        end
      end
      s1_valid_q <= accept;
      s1_res_q   <= accept && (col_q >= COL_W'(BORDER)) && (row_q >= HEIGHT_W'(BORDER));
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pix_q  <= pixel_i;
      s1_col_q  <= col_q;
      s1_last_q <= (col_q == col_last) && (row_q == row_last);
    end
  end

  // line stores: read at intake, written back in the next cycle
  always_ff @(posedge clk_i) begin
    if (accept) begin
      top_rd_q <= upper_mem[col_q];
      mid_rd_q <= middle_mem[col_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      upper_mem[s1_col_q]  <= mid_rd_q;
      middle_mem[s1_col_q] <= s1_pix_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) win_q[i] <= '0;
    end else if (s1_valid_q) begin
      win_q[0] <= win_q[3];
      win_q[1] <= win_q[4];
      win_q[2] <= win_q[5];
      win_q[3] <= top_rd_q;
      win_q[4] <= mid_rd_q;
      win_q[5] <= s1_pix_q;
    end
  end

  // kernel sums over the window
  always_comb begin
    sum_a = {2'b0, win_q[0]} + {1'b0, win_q[1], 1'b0} + {2'b0, win_q[2]};
    sum_c = {2'b0, top_rd_q} + {1'b0, mid_rd_q, 1'b0} + {2'b0, s1_pix_q};
    sum_t = {2'b0, win_q[0]} + {1'b0, win_q[3], 1'b0} + {2'b0, top_rd_q};
    sum_b = {2'b0, win_q[2]} + {1'b0, win_q[5], 1'b0} + {2'b0, s1_pix_q};
  end

  assign q_push_o      = s1_valid_q && s1_res_q;
  assign q_data_o.gx   = $signed({1'b0, sum_a}) - $signed({1'b0, sum_c});
  assign q_data_o.gy   = $signed({1'b0, sum_t}) - $signed({1'b0, sum_b});
  assign q_data_o.last = s1_last_q;

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push_o |-> (q_stat_i.count != QCNT_W'(QDEPTH)))
    else $error("gradient pushed into a full queue");

  a_res_only_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_res_q |-> $past(accept))
    else $error("gradient stage holds a result without an intake");

endmodule

>>> hdl/sgm_fifo.sv
// sgm_fifo: short queue of gradient pairs between front and back
// depends on sgm_pkg
module sgm_fifo
  import sgm_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  grad_t     data_i,
  input  logic      pop_i,
  output grad_t     data_o,
  output q_status_t stat_o
);

  grad_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0]  count_q;
  logic               do_push, do_pop;

  assign do_push = push_i && (count_q != QCNT_W'(QDEPTH));
  assign do_pop  = pop_i && (count_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      if (do_pop)  rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + QCNT_W'(1);
        2'b01:   count_q <= count_q - QCNT_W'(1);
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= data_i;
  end

  assign data_o       = mem_q[rd_ptr_q];
  assign stat_o.empty = (count_q == '0);
  assign stat_o.count = count_q;

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCNT_W'(QDEPTH))
    else $error("queue count beyond depth");

endmodule

>>> hdl/sgm_back.sv
// sgm_back: squares, sum and iterative integer square root, one result register
// depends on sgm_pkg; pops gradient pairs from sgm_fifo
module sgm_back
  import sgm_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  grad_t            q_data_i,
  input  q_status_t        q_stat_i,
  output logic             q_pop_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [MAG_W-1:0] magnitude_o,
  output logic             last_of_frame_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ADD,
    ST_ROOT,
    ST_PUT
  } state_e;

  state_e                   state_q;
  logic signed [GRAD_W-1:0] gx_q, gy_q;
  logic                     item_last_q;
  logic [SQR_W-1:0]         sqx_q, sqy_q;
  logic [SUM_W-1:0]         rem_q, bit_q;
  logic [ROOT_W-1:0]        root_q;
  logic                     out_valid_q, out_last_q;
  logic                     out_valid_d;
  logic [MAG_W-1:0]         out_mag_q;

  logic [ROOT_W-1:0]        trial;
  logic                     take;
  logic                     out_free;
  logic signed [2*GRAD_W-1:0] prod_x, prod_y;

  assign take     = (state_q == ST_IDLE) && !q_stat_i.empty;
  assign q_pop_o  = take;
  assign out_free = !out_valid_q || pop_i;
  assign trial    = root_q + {1'b0, bit_q};
  assign prod_x   = gx_q * gx_q;
  assign prod_y   = gy_q * gy_q;

  // output register: drained by pop, refilled by a finished result
  always_comb begin
    out_valid_d = out_valid_q;
    if (pop_i && out_valid_q) out_valid_d = 1'b0;
    if (state_q == ST_PUT && out_free) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      case (state_q)
        ST_IDLE: begin
          if (take) state_q <= ST_SQUARE;
        end
        ST_SQUARE: state_q <= ST_ADD;
        ST_ADD:    state_q <= ST_ROOT;
        ST_ROOT: begin
          if (bit_q[0]) state_q <= ST_PUT;
        end
        ST_PUT: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (take) begin
          gx_q        <= q_data_i.gx;
          gy_q        <= q_data_i.gy;
          item_last_q <= q_data_i.last;
        end
      end
      ST_SQUARE: begin
        sqx_q <= prod_x[SQR_W-1:0];
        sqy_q <= prod_y[SQR_W-1:0];
      end
      ST_ADD: begin
        rem_q  <= {1'b0, sqx_q} + {1'b0, sqy_q};
        root_q <= '0;
        bit_q  <= ROOT_START_BIT;
      end
      ST_ROOT: begin
        // one result bit per step
        if ({1'b0, rem_q} >= trial) begin
          rem_q  <= rem_q - trial[SUM_W-1:0];
          root_q <= (root_q >> 1) + {1'b0, bit_q};
        end else begin
          root_q <= root_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      ST_PUT: begin
        if (out_free) begin
          out_mag_q  <= root_q[MAG_W-1:0];
          out_last_q <= item_last_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign empty_o         = !out_valid_q;
  assign magnitude_o     = out_mag_q;
  assign last_of_frame_o = out_last_q;

  a_root_bit_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROOT) |-> (bit_q != '0))
    else $error("root step without a trial bit");

  a_put_fills_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PUT && out_free) |=> out_valid_q)
    else $error("finished result not loaded into the output register");

endmodule

>>> hdl/sobel_gradient_magnitude.sv
// sobel_gradient_magnitude: 3x3 sobel edge filter giving floor(sqrt(gx^2+gy^2))
// depends on sgm_pkg, sgm_front, sgm_fifo and sgm_back
// throughput: one pixel a cycle while the 4-entry gradient queue has room; the back end
//   works on one result at a time (square, add, 11 root steps, output load, pop)
// reset: counters, queue and output clear at once; line stores need no clearing pass
module sobel_gradient_magnitude
  import sgm_pkg::*;
#(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write channel
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // pixel queue side
  input  logic                  push_i,
  output logic                  full_o,
  input  logic [PIX_W-1:0]      pixel_i,
  // result queue side
  output logic                  empty_o,
  input  logic                  pop_i,
  output logic [MAG_W-1:0]      magnitude_o,
  output logic                  last_of_frame_o
);

  cfg_req_t  cfg_req;
  q_status_t q_stat;
  grad_t     q_wdata, q_rdata;
  logic      q_push, q_pop;

  // register writes are always taken; a write to either register restarts the frame
  assign cfg_ready_o   = 1'b1;
  assign cfg_req.valid = cfg_valid_i && cfg_ready_o;
  assign cfg_req.index = cfg_index_i;
  assign cfg_req.data  = cfg_data_i;

  // front: position tracking, line stores, window and gradient sums
  sgm_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_req),
    .push_i   (push_i),
    .pixel_i  (pixel_i),
    .full_o   (full_o),
    .q_stat_i (q_stat),
    .q_push_o (q_push),
    .q_data_o (q_wdata)
  );

  // decoupling queue, only interior pixels land here
  sgm_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (q_wdata),
    .pop_i  (q_pop),
    .data_o (q_rdata),
    .stat_o (q_stat)
  );

  // back: magnitude by shift-subtract square root
  sgm_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_data_i        (q_rdata),
    .q_stat_i        (q_stat),
    .q_pop_o         (q_pop),
    .pop_i           (pop_i),
    .empty_o         (empty_o),
    .magnitude_o     (magnitude_o),
    .last_of_frame_o (last_of_frame_o)
  );

endmodule

>>> tb/sobel_gradient_magnitude_sb_pkg.sv
// sobel_gradient_magnitude_sb_pkg: scoreboard for the sobel gradient magnitude testbench
// predicts magnitudes from accepted pixels and register writes; depends on sgm_pkg
package sobel_gradient_magnitude_sb_pkg;
  import sgm_pkg::*;

  localparam int LINE_DEPTH   = 2048;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [MAG_W-1:0] magnitude;
    logic             last_of_frame;
  } sobel_result_t;

  class gradient_scoreboard;
    logic [PIX_W-1:0]    upper_row [LINE_DEPTH];
    logic [PIX_W-1:0]    middle_row [LINE_DEPTH];
    // left column top/mid/bottom, then centre column top/mid/bottom
    logic [PIX_W-1:0]    window [6];
    int unsigned         col;
    int unsigned         row;
    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    sobel_result_t       expected_q [$];
    int unsigned         mismatches;

    function new();
      foreach (upper_row[i]) begin
        upper_row[i]  = '0;
        middle_row[i] = '0;
      end
      foreach (window[i]) window[i] = '0;
      col        = 0;
      row        = 0;
      width_reg  = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      mismatches = 0;
    endfunction

    function int unsigned row_length();
      if (width_reg < MIN_WIDTH) return MIN_WIDTH;
      if (width_reg > LINE_DEPTH) return LINE_DEPTH;
      return width_reg;
    endfunction

    function int unsigned frame_rows();
      return (height_reg < MIN_HEIGHT) ? MIN_HEIGHT : height_reg;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
      case (index)
        REG_IMAGE_WIDTH: begin
          width_reg = data[WIDTH_W-1:0];
          col = 0;
          row = 0;
        end
        REG_IMAGE_HEIGHT: begin
          height_reg = data[HEIGHT_W-1:0];
          col = 0;
          row = 0;
        end
        default: ;
      endcase
    endfunction

    // bitwise search for the largest root whose square fits
    function int unsigned root_floor(int unsigned sum);
      int unsigned root;
      int unsigned trial;
      root = 0;
      for (int b = MAG_W - 1; b >= 0; b--) begin
        trial = root | (1 << b);
        if (trial * trial <= sum) root = trial;
      end
      return root;
    endfunction

    function void note_pixel(logic [PIX_W-1:0] pix);
      int unsigned   w;
      int unsigned   h;
      int            gx;
      int            gy;
      logic [PIX_W-1:0] top;
      logic [PIX_W-1:0] mid;
      sobel_result_t res;
      w   = row_length();
      h   = frame_rows();
      top = upper_row[col];
      mid = middle_row[col];
      if (col >= BORDER && row >= BORDER) begin
        gx = (int'(window[0]) + 2 * int'(window[1]) + int'(window[2]))
           - (int'(top) + 2 * int'(mid) + int'(pix));
        gy = (int'(window[0]) + 2 * int'(window[3]) + int'(top))
           - (int'(window[2]) + 2 * int'(window[5]) + int'(pix));
        res.magnitude     = MAG_W'(root_floor(gx * gx + gy * gy));
        res.last_of_frame = (col == w - 1 && row == h - 1);
        expected_q = {expected_q, res};
      end
      upper_row[col]  = mid;
      middle_row[col] = pix;
      window[0] = window[3];
      window[1] = window[4];
      window[2] = window[5];
      window[3] = top;
      window[4] = mid;
      window[5] = pix;
      if (col == w - 1) begin
        col = 0;
        row = (row == h - 1) ? 0 : row + 1;
      end else begin
        col++;
      end
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) $display("%s", msg);
    endfunction

    function void check_result(logic [MAG_W-1:0] magnitude, logic last_of_frame);
      sobel_result_t want;
      if (expected_q.size() == 0) begin
        flag($sformatf("unexpected result: magnitude %0d last %0b", magnitude, last_of_frame));
      end else begin
        want = expected_q.pop_front();
        if (want.magnitude != magnitude || want.last_of_frame != last_of_frame)
          flag($sformatf("result mismatch: expected magnitude %0d last %0b, got %0d last %0b",
                         want.magnitude, want.last_of_frame, magnitude, last_of_frame));
      end
    endfunction
  endclass

endpackage

>>> tb/sobel_gradient_magnitude_tb.sv
// sobel_gradient_magnitude_tb: streams pixel frames through the sobel filter and checks
// every magnitude against the scoreboard; depends on sgm_pkg and sobel_gradient_magnitude_sb_pkg
module sobel_gradient_magnitude_tb;
  import sgm_pkg::*;
  import sobel_gradient_magnitude_sb_pkg::*;

  localparam int CLK_PERIOD     = 10;
  localparam int RESET_CYCLES   = 9;
  // extra wait once every expected result has been popped
  localparam int SETTLE_CYCLES  = 24;
  localparam int RANDOM_ITEMS   = 1100;
  localparam int WIDE_ITEMS     = 256;
  localparam int TIMEOUT_CYCLES = 2_000_000;
  localparam int MAX_BURST      = 24;

  // left column bright, right edge mixed: positive then negative gx
  localparam logic [PIX_W-1:0] STEP_FRAME [12] = '{
    8'd255, 8'd0, 8'd255, 8'd255,
    8'd255, 8'd0, 8'd0,   8'd0,
    8'd255, 8'd0, 8'd0,   8'd255
  };
  // bright top row and left column: strong diagonal gradient
  localparam logic [PIX_W-1:0] CORNER_FRAME [9] = '{
    8'd255, 8'd255, 8'd255,
    8'd255, 8'd0,   8'd0,
    8'd255, 8'd0,   8'd0
  };

  typedef enum logic [1:0] {
    POP_ALWAYS,
    POP_RANDOM,
    POP_STREAKS
  } pop_mode_e;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_write_t;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;
  logic                  push_i      = 1'b0;
  logic                  full_o;
  logic [PIX_W-1:0]      pixel_i     = '0;
  logic                  empty_o;
  logic                  pop_i       = 1'b0;
  logic [MAG_W-1:0]      magnitude_o;
  logic                  last_of_frame_o;

  gradient_scoreboard sb;
  cfg_write_t         cfg_writes [$];
  pop_mode_e          pop_mode   = POP_ALWAYS;
  int unsigned        max_gap    = 0;
  logic [PIX_W-1:0]   prev_pixel = '0;
  int unsigned        streak     = 0;
  bit                 stalling   = 1'b0;

  sobel_gradient_magnitude dut (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i,
    .push_i,
    .full_o,
    .pixel_i,
    .empty_o,
    .pop_i,
    .magnitude_o,
    .last_of_frame_o
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // observe every handshake at the rising edge, before the block updates its outputs
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) sb.write_register(cfg_index_i, cfg_data_i);
      if (push_i && !full_o) sb.note_pixel(pixel_i);
      if (pop_i && !empty_o) sb.check_result(magnitude_o, last_of_frame_o);
    end
  end

  // result side: always ready, coin flips, or long stall streaks
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      pop_i <= 1'b0;
    end else begin
      case (pop_mode)
        POP_ALWAYS: pop_i <= 1'b1;
        POP_RANDOM: pop_i <= 1'($urandom_range(0, 1));
        default: begin
          if (streak == 0) begin
            stalling = !stalling;
            streak   = stalling ? $urandom_range(1, 40) : $urandom_range(1, 12);
          end
          streak--;
          pop_i <= !stalling;
        end
      endcase
    end
  end

  // mostly random content, with flat stretches and saturated pixels mixed in
  function automatic logic [PIX_W-1:0] next_pixel();
    case ($urandom_range(0, 9))
      0:       prev_pixel = '1;
      1:       prev_pixel = '0;
      2, 3:    ;
      default: prev_pixel = PIX_W'($urandom_range(0, 255));
    endcase
    return prev_pixel;
  endfunction

  // append one register write to the pending list
  function automatic void queue_write(input logic [CFG_IDX_W-1:0] index,
                                      input logic [CFG_DATA_W-1:0] data);
    cfg_write_t wr;
    wr.index   = index;
    wr.data    = data;
    cfg_writes = {cfg_writes, wr};
  endfunction

  // called at a falling edge, returns at the falling edge after the request is taken
  task automatic send_pixel(input logic [PIX_W-1:0] value);
    push_i  <= 1'b1;
    pixel_i <= value;
    do @(posedge clk_i); while (full_o);
    @(negedge clk_i);
  endtask

  // bursts of random length, with random gaps bounded by max_gap between them
  task automatic send_stream(input int unsigned count);
    int unsigned burst;
    int unsigned gap;
    burst = $urandom_range(1, MAX_BURST);
    for (int unsigned n = 0; n < count; n++) begin
      send_pixel(next_pixel());
      burst--;
      if (burst == 0 && n + 1 < count) begin
        gap = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
        if (gap != 0) begin
          push_i <= 1'b0;
          repeat (gap) @(negedge clk_i);
        end
        burst = $urandom_range(1, MAX_BURST);
      end
    end
  endtask

  // back-to-back register writes from cfg_writes, valid dropped after the last
  task automatic write_config();
    foreach (cfg_writes[i]) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= cfg_writes[i].index;
      cfg_data_i  <= cfg_writes[i].data;
      do @(posedge clk_i); while (!cfg_ready_o);
      @(negedge clk_i);
    end
    cfg_valid_i <= 1'b0;
    cfg_writes.delete();
  endtask

  // stop pushing, collect every expected result, then let border pixels drain
  task automatic wait_idle();
    push_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // mostly small rows, some below the minimum, a few at or beyond the line store size
  function automatic logic [CFG_DATA_W-1:0] pick_width();
    int unsigned pick;
    logic [WIDTH_W-1:0] w;
    pick = $urandom_range(0, 19);
    if (pick < 12)      w = WIDTH_W'($urandom_range(3, 10));
    else if (pick < 14) w = WIDTH_W'($urandom_range(0, 2));
    else if (pick < 17) w = WIDTH_W'($urandom_range(11, 40));
    else if (pick < 18) w = WIDTH_W'(LINE_DEPTH);
    else                w = WIDTH_W'($urandom_range(LINE_DEPTH + 1, (1 << WIDTH_W) - 1));
    // upper data bits are don't-care for the width register
    return {(CFG_DATA_W - WIDTH_W)'($urandom), w};
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_height();
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick < 11) return CFG_DATA_W'($urandom_range(3, 6));
    if (pick < 14) return CFG_DATA_W'($urandom_range(0, 2));
    if (pick < 16) return '1;
    return CFG_DATA_W'($urandom_range(7, 300));
  endfunction

  initial begin
    int unsigned random_items;
    int unsigned count;
    int unsigned frame_len;
    sb = new();
    random_items = 0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset geometry is 640 wide, so a few pixels give no result
    send_stream(5);
    wait_idle();

    // directed frames: step edges with both signs of gx, then a bright corner
    queue_write(REG_IMAGE_WIDTH, CFG_DATA_W'(4));
    queue_write(REG_IMAGE_HEIGHT, CFG_DATA_W'(3));
    write_config();
    foreach (STEP_FRAME[i]) send_pixel(STEP_FRAME[i]);
    wait_idle();
    queue_write(REG_IMAGE_WIDTH, CFG_DATA_W'(3));
    write_config();
    foreach (CORNER_FRAME[i]) send_pixel(CORNER_FRAME[i]);
    wait_idle();

    // widest row: width clamps to the line store size, part of the first row only
    queue_write(REG_IMAGE_WIDTH, '1);
    queue_write(REG_IMAGE_HEIGHT, CFG_DATA_W'(3));
    write_config();
    pop_mode = POP_RANDOM;
    max_gap  = 0;
    send_stream(WIDE_ITEMS);
    wait_idle();

    // random phases: new geometry, restarts mid-frame, ignored register indexes
    while (random_items < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) < 7) queue_write(REG_IMAGE_WIDTH, pick_width());
      if ($urandom_range(0, 9) < 6) queue_write(REG_IMAGE_HEIGHT, pick_height());
      if ($urandom_range(0, 4) == 0)
        queue_write(CFG_IDX_W'($urandom_range(REG_IMAGE_HEIGHT + 1, (1 << CFG_IDX_W) - 1)),
                    CFG_DATA_W'($urandom));
      write_config();
      pop_mode = pop_mode_e'($urandom_range(POP_ALWAYS, POP_STREAKS));
      max_gap  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      // huge rows never reach the interior here, so keep those phases short
      if (sb.row_length() > 64) begin
        count = $urandom_range(10, 60);
      end else begin
        frame_len = 3 * sb.row_length() * sb.frame_rows() + 4;
        count     = $urandom_range(1, (frame_len < 240) ? frame_len : 240);
      end
      send_stream(count);
      random_items += count;
      wait_idle();
    end

    if (sb.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // hard stop if a handshake never completes
  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("Verification failed");
    $finish;
  end

endmodule
